// ===== rtl/core/assert_macros.svh =====
// Assertion macros for the RTL files of the traversal block (used by graph_dfs_order).
// Property forms for implication in the same cycle and in the next cycle.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_SAME(lbl, clk, rstn, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

// ===== rtl/core/gdfs_pkg.sv =====
// Package of the graph traversal block: sizes, operation codes, request type.
// No dependencies.
`default_nettype none
package gdfs_pkg;
    localparam int MAX_VERTICES = 64;
    localparam int EDGE_SLOTS   = 512;
    localparam int VIDX_W       = $clog2(MAX_VERTICES);
    localparam int DEPTH_W      = $clog2(MAX_VERTICES + 1);
    localparam int SLOT_W       = $clog2(EDGE_SLOTS);
    localparam int LINK_W       = $clog2(EDGE_SLOTS + 1);
    localparam int VERTEX_W     = 6;
    localparam int COUNT_W      = 7;
    localparam int STAMP_W      = 7;
    localparam int TIME_W       = 8;

    localparam logic [LINK_W-1:0]  NULL_LINK   = LINK_W'(EDGE_SLOTS);
    localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(64);

    localparam logic OP_ADD_EDGE = 1'b0;
    localparam logic OP_RUN      = 1'b1;

    typedef struct packed {
        logic               push;
        logic               flush;
        logic [VIDX_W-1:0]  vertex;
        logic [STAMP_W-1:0] stamp;
    } result_req_t;
endpackage
`default_nettype wire

// ===== rtl/core/gdfs_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none
module gdfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
endmodule
`default_nettype wire

// ===== rtl/core/gdfs_result_buf.sv =====
// Result holding stage: keeps the latest discovery until the next one or the
// end of the run marks it, then hands it to the output register. Uses gdfs_pkg.
`default_nettype none
module gdfs_result_buf (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire gdfs_pkg::result_req_t         req,
    output logic                               room,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [gdfs_pkg::VERTEX_W-1:0]      m_visited_vertex,
    output logic [gdfs_pkg::STAMP_W-1:0]       m_discovery_time,
    output logic                               m_last_visit
);
    import gdfs_pkg::*;

    logic                pend_valid_reg, pend_valid_next;
    logic [VIDX_W-1:0]   pend_vertex_reg, pend_vertex_next;
    logic [STAMP_W-1:0]  pend_stamp_reg, pend_stamp_next;
    logic                out_valid_reg, out_valid_next;
    logic [VERTEX_W-1:0] out_vertex_reg, out_vertex_next;
    logic [STAMP_W-1:0]  out_stamp_reg, out_stamp_next;
    logic                out_last_reg, out_last_next;
    logic                out_free;

    assign out_free = !out_valid_reg || m_ready;
    assign room     = !pend_valid_reg || out_free;

    always_comb begin
        pend_valid_next  = pend_valid_reg;
        pend_vertex_next = pend_vertex_reg;
        pend_stamp_next  = pend_stamp_reg;
        out_valid_next   = out_valid_reg && !m_ready;
        out_vertex_next  = out_vertex_reg;
        out_stamp_next   = out_stamp_reg;
        out_last_next    = out_last_reg;
        if ((req.push || req.flush) && pend_valid_reg) begin
            out_valid_next  = 1'b1;
            out_vertex_next = VERTEX_W'(pend_vertex_reg);
            out_stamp_next  = pend_stamp_reg;
            out_last_next   = req.flush;
            pend_valid_next = 1'b0;
        end
        if (req.push) begin
            pend_valid_next  = 1'b1;
            pend_vertex_next = req.vertex;
            pend_stamp_next  = req.stamp;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            pend_valid_reg  <= pend_valid_next;
            out_valid_reg   <= out_valid_next;
            pend_vertex_reg <= pend_vertex_next;
            pend_stamp_reg  <= pend_stamp_next;
            out_vertex_reg  <= out_vertex_next;
            out_stamp_reg   <= out_stamp_next;
            out_last_reg    <= out_last_next;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_visited_vertex = out_vertex_reg;
    assign m_discovery_time = out_stamp_reg;
    assign m_last_visit     = out_last_reg;
endmodule
`default_nettype wire

// ===== rtl/core/graph_dfs_order.sv =====
// Edge request: accept, link second endpoint, link first endpoint.
// Run request: accept, then try roots, discover vertices, read adjacency entries,
// finish vertices and end; output stalls can hold the walk. Each result leaves one
// discovery later, the last at the end.
// The walk loop alternates a list or stack memory read with an update step.
// Reset: empty graph, vertex count 64; list heads invalid through valid bits, no sweep.
`default_nettype none
`include "assert_macros.svh"
module graph_dfs_order (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic                          s_operation,
    input  wire logic [gdfs_pkg::VERTEX_W-1:0] s_from_vertex,
    input  wire logic [gdfs_pkg::VERTEX_W-1:0] s_to_vertex,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [gdfs_pkg::VERTEX_W-1:0]      m_visited_vertex,
    output logic [gdfs_pkg::STAMP_W-1:0]       m_discovery_time,
    output logic                               m_last_visit,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [gdfs_pkg::COUNT_W-1:0]  cfg_data
);
    import gdfs_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_E_LINK_B,
        ST_E_LINK_A,
        ST_R_ROOT,
        ST_R_HEAD,
        ST_R_WALK,
        ST_R_EDGE,
        ST_R_POP,
        ST_R_END
    } state_t;

    state_t                  state_reg, state_next;
    logic [COUNT_W-1:0]      vcount_reg;
    logic [LINK_W-1:0]       fill_reg, fill_next;
    logic [MAX_VERTICES-1:0] head_vld_reg, head_vld_next;
    logic [MAX_VERTICES-1:0] seen_reg, seen_next;
    logic [TIME_W-1:0]       time_reg, time_next;
    logic [COUNT_W-1:0]      root_reg, root_next;
    logic [DEPTH_W-1:0]      depth_reg, depth_next;
    logic [VIDX_W-1:0]       top_v_reg, top_v_next;
    logic [LINK_W-1:0]       top_c_reg, top_c_next;
    logic [VIDX_W-1:0]       edge_a_reg, edge_a_next;
    logic [VIDX_W-1:0]       edge_b_reg, edge_b_next;
    logic [VIDX_W-1:0]       head_idx_reg;

    logic                      head_rd_en, head_wr_en;
    logic [VIDX_W-1:0]         head_rd_addr, head_wr_addr;
    logic [LINK_W-1:0]         head_wr_data, head_rdata, head_q;
    logic                      edge_rd_en, edge_wr_en;
    logic [SLOT_W-1:0]         edge_rd_addr, edge_wr_addr;
    logic [VIDX_W+LINK_W-1:0]  edge_wr_data, edge_rdata;
    logic                      stk_rd_en, stk_wr_en;
    logic [VIDX_W-1:0]         stk_rd_addr, stk_wr_addr;
    logic [VIDX_W+LINK_W-1:0]  stk_wr_data, stk_rdata;

    logic [COUNT_W-1:0] n_eff;
    logic               edge_ok;
    logic [TIME_W-1:0]  time_inc;
    logic [DEPTH_W-1:0] depth_m1, depth_m2;
    logic [VIDX_W-1:0]  root_idx, edge_nbr;
    logic [LINK_W-1:0]  edge_link;
    result_req_t        res_req;
    logic               res_room;

    assign n_eff     = (vcount_reg > COUNT_W'(MAX_VERTICES)) ? COUNT_W'(MAX_VERTICES)
                                                            : vcount_reg;
    assign edge_ok   = (COUNT_W'(s_from_vertex) < n_eff) && (COUNT_W'(s_to_vertex) < n_eff)
                       && (fill_reg <= LINK_W'(EDGE_SLOTS - 2));
    assign time_inc  = time_reg + TIME_W'(1);
    assign depth_m1  = depth_reg - DEPTH_W'(1);
    assign depth_m2  = depth_reg - DEPTH_W'(2);
    assign root_idx  = root_reg[VIDX_W-1:0];
    assign edge_nbr  = edge_rdata[LINK_W +: VIDX_W];
    assign edge_link = edge_rdata[LINK_W-1:0];
    assign head_q    = head_vld_reg[head_idx_reg] ? head_rdata : NULL_LINK;
    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;

    always_comb begin
        state_next    = state_reg;
        fill_next     = fill_reg;
        head_vld_next = head_vld_reg;
        seen_next     = seen_reg;
        time_next     = time_reg;
        root_next     = root_reg;
        depth_next    = depth_reg;
        top_v_next    = top_v_reg;
        top_c_next    = top_c_reg;
        edge_a_next   = edge_a_reg;
        edge_b_next   = edge_b_reg;
        head_rd_en    = 1'b0;
        head_rd_addr  = '0;
        head_wr_en    = 1'b0;
        head_wr_addr  = '0;
        head_wr_data  = '0;
        edge_rd_en    = 1'b0;
        edge_rd_addr  = '0;
        edge_wr_en    = 1'b0;
        edge_wr_addr  = '0;
        edge_wr_data  = '0;
        stk_rd_en     = 1'b0;
        stk_rd_addr   = '0;
        stk_wr_en     = 1'b0;
        stk_wr_addr   = '0;
        stk_wr_data   = '0;
        res_req       = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_operation == OP_RUN) begin
                        seen_next  = '0;
                        time_next  = '0;
                        root_next  = '0;
                        depth_next = '0;
                        state_next = ST_R_ROOT;
                    end else if (edge_ok) begin
                        edge_a_next  = s_from_vertex[VIDX_W-1:0];
                        edge_b_next  = s_to_vertex[VIDX_W-1:0];
                        head_rd_en   = 1'b1;
                        head_rd_addr = s_to_vertex[VIDX_W-1:0];
                        state_next   = ST_E_LINK_B;
                    end
                end
            end
            ST_E_LINK_B: begin
                edge_wr_en                = 1'b1;
                edge_wr_addr              = fill_reg[SLOT_W-1:0];
                edge_wr_data              = {edge_a_reg, head_q};
                head_wr_en                = 1'b1;
                head_wr_addr              = edge_b_reg;
                head_wr_data              = fill_reg;
                head_vld_next[edge_b_reg] = 1'b1;
                fill_next                 = fill_reg + LINK_W'(1);
                head_rd_en                = 1'b1;
                head_rd_addr              = edge_a_reg;
                state_next                = ST_E_LINK_A;
            end
            ST_E_LINK_A: begin
                edge_wr_en   = 1'b1;
                edge_wr_addr = fill_reg[SLOT_W-1:0];
                // self loop: head was rewritten in the previous cycle
                edge_wr_data = {edge_b_reg, (edge_a_reg == edge_b_reg)
                                ? (fill_reg - LINK_W'(1)) : head_q};
                head_wr_en                = 1'b1;
                head_wr_addr              = edge_a_reg;
                head_wr_data              = fill_reg;
                head_vld_next[edge_a_reg] = 1'b1;
                fill_next                 = fill_reg + LINK_W'(1);
                state_next                = ST_IDLE;
            end
            ST_R_ROOT: begin
                if (root_reg >= n_eff) begin
                    state_next = ST_R_END;
                end else if (seen_reg[root_idx]) begin
                    root_next = root_reg + COUNT_W'(1);
                end else if (res_room) begin
                    time_next          = time_inc;
                    seen_next[root_idx] = 1'b1;
                    res_req.push       = 1'b1;
                    res_req.vertex     = root_idx;
                    res_req.stamp      = time_inc[STAMP_W-1:0];
                    head_rd_en         = 1'b1;
                    head_rd_addr       = root_idx;
                    state_next         = ST_R_HEAD;
                end
            end
            ST_R_HEAD: begin
                top_v_next = head_idx_reg;
                top_c_next = head_q;
                depth_next = depth_reg + DEPTH_W'(1);
                state_next = ST_R_WALK;
            end
            ST_R_WALK: begin
                if (depth_reg == '0) begin
                    root_next  = root_reg + COUNT_W'(1);
                    state_next = ST_R_ROOT;
                end else if (top_c_reg >= NULL_LINK) begin
                    time_next  = time_inc;
                    depth_next = depth_m1;
                    if (depth_reg > DEPTH_W'(1)) begin
                        stk_rd_en   = 1'b1;
                        stk_rd_addr = depth_m2[VIDX_W-1:0];
                        state_next  = ST_R_POP;
                    end
                end else begin
                    edge_rd_en   = 1'b1;
                    edge_rd_addr = top_c_reg[SLOT_W-1:0];
                    state_next   = ST_R_EDGE;
                end
            end
            ST_R_EDGE: begin
                if ((COUNT_W'(edge_nbr) < n_eff) && !seen_reg[edge_nbr]
                    && (depth_reg < DEPTH_W'(MAX_VERTICES))) begin
                    if (res_room) begin
                        stk_wr_en           = 1'b1;
                        stk_wr_addr         = depth_m1[VIDX_W-1:0];
                        stk_wr_data         = {top_v_reg, edge_link};
                        time_next           = time_inc;
                        seen_next[edge_nbr] = 1'b1;
                        res_req.push        = 1'b1;
                        res_req.vertex      = edge_nbr;
                        res_req.stamp       = time_inc[STAMP_W-1:0];
                        head_rd_en          = 1'b1;
                        head_rd_addr        = edge_nbr;
                        state_next          = ST_R_HEAD;
                    end
                end else begin
                    top_c_next = edge_link;
                    state_next = ST_R_WALK;
                end
            end
            ST_R_POP: begin
                top_v_next = stk_rdata[LINK_W +: VIDX_W];
                top_c_next = stk_rdata[LINK_W-1:0];
                state_next = ST_R_WALK;
            end
            ST_R_END: begin
                if (res_room) begin
                    res_req.flush = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            vcount_reg   <= COUNT_RESET;
            fill_reg     <= '0;
            head_vld_reg <= '0;
            seen_reg     <= '0;
            time_reg     <= '0;
            root_reg     <= '0;
            depth_reg    <= '0;
        end else begin
            state_reg    <= state_next;
            if (cfg_valid && cfg_ready) begin
                vcount_reg <= cfg_data;
            end
            fill_reg     <= fill_next;
            head_vld_reg <= head_vld_next;
            seen_reg     <= seen_next;
            time_reg     <= time_next;
            root_reg     <= root_next;
            depth_reg    <= depth_next;
            top_v_reg    <= top_v_next;
            top_c_reg    <= top_c_next;
            edge_a_reg   <= edge_a_next;
            edge_b_reg   <= edge_b_next;
            if (head_rd_en) begin
                head_idx_reg <= head_rd_addr;
            end
        end
    end

    gdfs_ram #(.WIDTH(LINK_W), .DEPTH(MAX_VERTICES)) u_head_ram (
        .aclk    (aclk),
        .wr_en   (head_wr_en),
        .wr_addr (head_wr_addr),
        .wr_data (head_wr_data),
        .rd_en   (head_rd_en),
        .rd_addr (head_rd_addr),
        .rd_data (head_rdata)
    );

    gdfs_ram #(.WIDTH(VIDX_W + LINK_W), .DEPTH(EDGE_SLOTS)) u_edge_ram (
        .aclk    (aclk),
        .wr_en   (edge_wr_en),
        .wr_addr (edge_wr_addr),
        .wr_data (edge_wr_data),
        .rd_en   (edge_rd_en),
        .rd_addr (edge_rd_addr),
        .rd_data (edge_rdata)
    );

    gdfs_ram #(.WIDTH(VIDX_W + LINK_W), .DEPTH(MAX_VERTICES)) u_stack_ram (
        .aclk    (aclk),
        .wr_en   (stk_wr_en),
        .wr_addr (stk_wr_addr),
        .wr_data (stk_wr_data),
        .rd_en   (stk_rd_en),
        .rd_addr (stk_rd_addr),
        .rd_data (stk_rdata)
    );

    gdfs_result_buf u_result_buf (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .req              (res_req),
        .room             (res_room),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_visited_vertex (m_visited_vertex),
        .m_discovery_time (m_discovery_time),
        .m_last_visit     (m_last_visit)
    );

    `ASSERT_SAME(a_push_has_room, aclk, aresetn, res_req.push || res_req.flush, res_room, "result request without room")
    `ASSERT_SAME(a_fill_bound, aclk, aresetn, 1'b1, fill_reg <= NULL_LINK, "edge fill past store size")
    `ASSERT_SAME(a_pop_depth, aclk, aresetn, state_reg == ST_R_POP, depth_reg != '0, "pop with empty stack")
    `ASSERT_NEXT(a_run_start, aclk, aresetn, s_valid && s_ready && s_operation == OP_RUN, state_reg == ST_R_ROOT && time_reg == '0 && seen_reg == '0, "run did not start clean")
endmodule
`default_nettype wire
